### hdl/udpp_pkg.sv
// Shared types and constants for the UDP/IP frame parser.
package udpp_pkg;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [15:0] ETH_IPV6  = 16'h86DD;
	localparam logic [7:0]  PROTO_UDP = 8'h11;
	localparam logic [15:0] FRAG_DF   = 16'h4000;
	localparam logic [3:0]  IP_VER4   = 4'd4;
	localparam logic [3:0]  IP_VER6   = 4'd6;
	localparam logic [3:0]  IHL_MIN   = 4'd5;

	localparam int          HDR_LEN_W = 7;
	localparam logic [HDR_LEN_W-1:0] LEN_SAT      = 7'd127;
	localparam logic [HDR_LEN_W-1:0] LEN_ETH      = 7'd14;
	localparam logic [HDR_LEN_W-1:0] LEN_V4_FRAG  = 7'd22;
	localparam logic [HDR_LEN_W-1:0] LEN_V4_PROTO = 7'd24;
	localparam logic [HDR_LEN_W-1:0] LEN_V6_VER   = 7'd15;
	localparam logic [HDR_LEN_W-1:0] LEN_V6_UDP   = 7'd62;
	localparam logic [HDR_LEN_W-1:0] V6_UDP_START = 7'd54;
	localparam logic [HDR_LEN_W-1:0] V6_ADDR_START = 7'd22;
	localparam logic [HDR_LEN_W-1:0] UDP_HDR_LEN  = 7'd8;

	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_VER   = 3'd1,
		ST_NOT_UDP   = 3'd2,
		ST_BAD_ETYPE = 3'd3,
		ST_TRUNC     = 3'd4
	} status_t;

	typedef struct packed {
		logic [HDR_LEN_W-1:0] len;
		logic [15:0]          ether_type;
		logic [47:0]          dst_mac;
		logic [47:0]          src_mac;
		logic [7:0]           vihl;
		logic [23:0]          frag_proto;
		logic [3:0][63:0]     addr;
		logic [47:0]          udp;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [HDR_LEN_W-1:0] v4_udp_start(input logic [3:0] ihl);
		v4_udp_start = LEN_ETH + {1'b0, ihl, 2'b00};
	endfunction

endpackage

### hdl/udpp_front.sv
// Front end: accepts frame bytes, tracks offset, captures header fields.
module udpp_front import udpp_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frame_valid,
	output logic       frame_stall,
	input  logic [7:0] frame_byte,
	input  logic       last,
	input  q_stat_t    q_stat,
	output logic       push,
	output frame_rec_t rec
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	logic [CW-1:0]        cnt_q, cnt_nxt;
	logic [15:0]          et_q, et_d;
	logic [47:0]          dmac_q, dmac_d, smac_q, smac_d;
	logic [7:0]           vihl_q, vihl_d;
	logic [23:0]          fp_q, fp_d;
	logic [3:0][63:0]     addr_q, addr_d;
	logic [47:0]          udp_q, udp_d;
	logic                 accept, cap_en, hdr;
	logic [HDR_LEN_W-1:0] pos, u, a_off;

	assign frame_stall = q_stat.full;
	assign accept      = frame_valid && !frame_stall;
	assign cap_en      = accept && (cnt_q < CW'(MAX_FRAME_BYTES));
	assign hdr         = ((cnt_q >> HDR_LEN_W) == '0);
	assign pos         = cnt_q[HDR_LEN_W-1:0];
	assign u           = v4_udp_start(vihl_q[3:0]);
	assign a_off       = pos - V6_ADDR_START;
	assign cnt_nxt     = cap_en ? cnt_q + CW'(1) : cnt_q;

	always_comb begin
		et_d   = et_q;
		dmac_d = dmac_q;
		smac_d = smac_q;
		vihl_d = vihl_q;
		fp_d   = fp_q;
		addr_d = addr_q;
		udp_d  = udp_q;
		if (cap_en && hdr) begin
			if (pos < 7'd6) begin
				dmac_d = {dmac_q[39:0], frame_byte};
			end else if (pos < 7'd12) begin
				smac_d = {smac_q[39:0], frame_byte};
			end else if (pos < LEN_ETH) begin
				et_d = {et_q[7:0], frame_byte};
			end else begin
				if (pos == LEN_ETH)
					vihl_d = frame_byte;
				if (et_q == ETH_IPV4) begin
					if (pos == 7'd20 || pos == 7'd21 || pos == 7'd23)
						fp_d = {fp_q[15:0], frame_byte};
					if (pos >= 7'd26 && pos < 7'd30)
						addr_d[1] = {addr_q[1][55:0], frame_byte};
					if (pos >= 7'd30 && pos < 7'd34)
						addr_d[3] = {addr_q[3][55:0], frame_byte};
					if (vihl_q[3:0] >= IHL_MIN && pos >= u && pos < u + 7'd6)
						udp_d = {udp_q[39:0], frame_byte};
				end else if (et_q == ETH_IPV6) begin
					if (pos >= V6_ADDR_START && pos < V6_UDP_START) begin
						for (int i = 0; i < 4; i++) begin
							if (a_off[4:3] == 2'(i))
								addr_d[i] = {addr_q[i][55:0], frame_byte};
						end
					end
					if (pos >= V6_UDP_START && pos < V6_UDP_START + 7'd6)
						udp_d = {udp_q[39:0], frame_byte};
				end
			end
		end
	end

	assign push            = accept && last;
	assign rec.len         = ((cnt_nxt >> HDR_LEN_W) != '0) ? LEN_SAT
	                                                      : cnt_nxt[HDR_LEN_W-1:0];
	assign rec.ether_type  = et_d;
	assign rec.dst_mac     = dmac_d;
	assign rec.src_mac     = smac_d;
	assign rec.vihl        = vihl_d;
	assign rec.frag_proto  = fp_d;
	assign rec.addr        = addr_d;
	assign rec.udp         = udp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			et_q   <= '0;
			dmac_q <= '0;
			smac_q <= '0;
			vihl_q <= '0;
			fp_q   <= '0;
			addr_q <= '0;
			udp_q  <= '0;
		end else if (push) begin
			cnt_q  <= '0;
			et_q   <= '0;
			dmac_q <= '0;
			smac_q <= '0;
			vihl_q <= '0;
			fp_q   <= '0;
			addr_q <= '0;
			udp_q  <= '0;
		end else if (cap_en) begin
			cnt_q  <= cnt_nxt;
			et_q   <= et_d;
			dmac_q <= dmac_d;
			smac_q <= smac_d;
			vihl_q <= vihl_d;
			fp_q   <= fp_d;
			addr_q <= addr_d;
			udp_q  <= udp_d;
		end
	end

endmodule

### hdl/udpp_queue.sv
// Two-entry queue of captured frame records between front and back.
module udpp_queue import udpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t wr_rec,
	input  logic       pop,
	output frame_rec_t rd_rec,
	output q_stat_t    q_stat
);

	localparam int PW = $clog2(QDEPTH);
	localparam int NW = $clog2(QDEPTH + 1);

	frame_rec_t    ent_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == NW'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign rd_rec       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (pop)
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/udpp_back.sv
// Back end: judges a frame record and holds the result in an output register.
module udpp_back import udpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_rec_t  rec,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic        is_ipv6,
	output logic [47:0] src_mac,
	output logic [47:0] dst_mac,
	output logic [63:0] src_addr_hi,
	output logic [63:0] src_addr_lo,
	output logic [63:0] dst_addr_hi,
	output logic [63:0] dst_addr_lo,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [10:0] payload_offset,
	output logic [15:0] udp_data_len
);

	status_t              st;
	logic [3:0]           ver, ihl;
	logic [15:0]          frag, ulen;
	logic [HDR_LEN_W-1:0] u, poff;
	logic                 ok, v6;

	assign ver  = rec.vihl[7:4];
	assign ihl  = rec.vihl[3:0];
	assign frag = rec.frag_proto[23:8];
	assign u    = v4_udp_start(ihl);
	assign v6   = (rec.ether_type == ETH_IPV6);
	assign ulen = rec.udp[15:0];
	assign poff = v6 ? LEN_V6_UDP : u + UDP_HDR_LEN;

	always_comb begin
		if (rec.len < LEN_ETH)
			st = ST_TRUNC;
		else if (rec.ether_type == ETH_IPV4) begin
			if (rec.len < LEN_V4_FRAG)
				st = ST_TRUNC;
			else if (ver != IP_VER4 || ihl < IHL_MIN || (frag & ~FRAG_DF) != '0)
				st = ST_BAD_VER;
			else if (rec.len < LEN_V4_PROTO)
				st = ST_TRUNC;
			else if (rec.frag_proto[7:0] != PROTO_UDP)
				st = ST_NOT_UDP;
			else if (rec.len < u + UDP_HDR_LEN)
				st = ST_TRUNC;
			else
				st = ST_OK;
		end else if (v6) begin
			if (rec.len < LEN_V6_VER)
				st = ST_TRUNC;
			else if (ver != IP_VER6)
				st = ST_BAD_VER;
			else if (rec.len < LEN_V6_UDP)
				st = ST_TRUNC;
			else
				st = ST_OK;
		end else
			st = ST_BAD_ETYPE;
	end

	assign ok  = (st == ST_OK);
	assign pop = !q_stat.empty && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (pop)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status         <= st;
			is_ipv6        <= ok && v6;
			src_mac        <= ok ? rec.src_mac : '0;
			dst_mac        <= ok ? rec.dst_mac : '0;
			src_addr_hi    <= ok ? rec.addr[0] : '0;
			src_addr_lo    <= ok ? rec.addr[1] : '0;
			dst_addr_hi    <= ok ? rec.addr[2] : '0;
			dst_addr_lo    <= ok ? rec.addr[3] : '0;
			src_port       <= ok ? rec.udp[47:32] : '0;
			dst_port       <= ok ? rec.udp[31:16] : '0;
			payload_offset <= ok ? 11'(poff) : '0;
			udp_data_len   <= (ok && ulen >= 16'd8) ? ulen - 16'd8 : '0;
		end
	end

endmodule

### hdl/udp_ip_frame_parser_top.sv
// Top level of the Ethernet/IPv4/IPv6/UDP header parser.
//
// Input channel: frame_valid/frame_stall carry one frame byte per item, with
// last marking the final byte. Output channel: result_valid/result_stall carry
// one header result per frame, issued for the item that has last set.
// Bytes are taken at one per cycle while frame_stall is low; the front end
// captures header fields as they pass and hands a frame record into a
// two-entry queue on the last byte. The back end takes records from the queue,
// checks each one and loads the output register, which raises result_valid;
// back-to-back results leave at one per cycle while result_stall is low.
// frame_stall rises only when the queue is full, which happens when the
// receiver holds result_stall across several frame ends; the captured result
// stays unchanged while stalled.
// Bytes past MAX_FRAME_BYTES are neither counted nor captured.
// Reset clears the byte counter, all capture registers, the queue and
// result_valid; the first accepted byte after reset starts a new frame.
module udp_ip_frame_parser_top import udpp_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic        is_ipv6,
	output logic [47:0] src_mac,
	output logic [47:0] dst_mac,
	output logic [63:0] src_addr_hi,
	output logic [63:0] src_addr_lo,
	output logic [63:0] dst_addr_hi,
	output logic [63:0] dst_addr_lo,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [10:0] payload_offset,
	output logic [15:0] udp_data_len
);

	frame_rec_t wr_rec, rd_rec;
	q_stat_t    q_stat;
	logic       push, pop;

	udpp_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.last        (last),
		.q_stat      (q_stat),
		.push        (push),
		.rec         (wr_rec)
	);

	udpp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.q_stat (q_stat)
	);

	udpp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec            (rd_rec),
		.q_stat         (q_stat),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.is_ipv6        (is_ipv6),
		.src_mac        (src_mac),
		.dst_mac        (dst_mac),
		.src_addr_hi    (src_addr_hi),
		.src_addr_lo    (src_addr_lo),
		.dst_addr_hi    (dst_addr_hi),
		.dst_addr_lo    (dst_addr_lo),
		.src_port       (src_port),
		.dst_port       (dst_port),
		.payload_offset (payload_offset),
		.udp_data_len   (udp_data_len)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("frame record pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("frame record popped from empty queue");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |->
			!is_ipv6 && src_mac == '0 && dst_port == '0 && udp_data_len == '0
			&& payload_offset == '0)
		else $error("failed result carries nonzero fields");

	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OK |->
			(is_ipv6 && payload_offset == 11'd62)
			|| (!is_ipv6 && payload_offset >= 11'd42 && payload_offset <= 11'd82))
		else $error("payload offset out of range for good frame");

endmodule

### test/udp_ip_frame_parser_top_test.sv
// Self-checking testbench for udp_ip_frame_parser_top: byte-wise frames in, header results checked.
module udp_ip_frame_parser_top_test;
	import udpp_pkg::*;

	localparam int MAX_BYTES = 2048;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT = 10;
	localparam int PHASE_BYTES = 363;
	localparam int PHASE_FRAMES = 10;

	typedef struct packed {
		status_t     st;
		logic        v6;
		logic [47:0] smac;
		logic [47:0] dmac;
		logic [63:0] sah;
		logic [63:0] sal;
		logic [63:0] dah;
		logic [63:0] dal;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [10:0] poff;
		logic [15:0] plen;
	} hdr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frame_valid = 1'b0;
	logic        frame_stall;
	logic [7:0]  frame_byte = 8'h00;
	logic        last = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic        is_ipv6;
	logic [47:0] src_mac;
	logic [47:0] dst_mac;
	logic [63:0] src_addr_hi;
	logic [63:0] src_addr_lo;
	logic [63:0] dst_addr_hi;
	logic [63:0] dst_addr_lo;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [10:0] payload_offset;
	logic [15:0] udp_data_len;

	udp_ip_frame_parser_top #(.MAX_FRAME_BYTES(MAX_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_byte(frame_byte),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.is_ipv6(is_ipv6),
		.src_mac(src_mac),
		.dst_mac(dst_mac),
		.src_addr_hi(src_addr_hi),
		.src_addr_lo(src_addr_lo),
		.dst_addr_hi(dst_addr_hi),
		.dst_addr_lo(dst_addr_lo),
		.src_port(src_port),
		.dst_port(dst_port),
		.payload_offset(payload_offset),
		.udp_data_len(udp_data_len)
	);

	// header capture state of the frame in flight
	int unsigned hdr_pos = 0;
	logic [15:0] hdr_etype = '0;
	logic [47:0] hdr_dmac = '0;
	logic [47:0] hdr_smac = '0;
	logic [7:0]  hdr_vihl = '0;
	logic [23:0] hdr_fragp = '0;
	logic [63:0] hdr_addr [4] = '{default: '0};
	logic [47:0] hdr_udp = '0;

	hdr_result_t pending_headers [$];
	logic [7:0]  frame_buf [$];

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int clean_v4 = 0;
	int clean_v6 = 0;
	int rejected = 0;
	int drain_cycles = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_headers.size());
			$display("** udp_ip_frame_parser_top: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned udp_base();
		if (hdr_etype == ETH_IPV6)
			return V6_UDP_START;
		return LEN_ETH + 4 * int'(hdr_vihl[3:0]);
	endfunction

	function automatic status_t classify_frame();
		int unsigned n;
		logic [15:0] frag;
		n = hdr_pos;
		frag = hdr_fragp[23:8];
		if (n < LEN_ETH)
			return ST_TRUNC;
		if (hdr_etype == ETH_IPV4) begin
			if (n < LEN_V4_FRAG)
				return ST_TRUNC;
			if (hdr_vihl[7:4] != IP_VER4 || hdr_vihl[3:0] < IHL_MIN || (frag & ~FRAG_DF) != 16'h0)
				return ST_BAD_VER;
			if (n < LEN_V4_PROTO)
				return ST_TRUNC;
			if (hdr_fragp[7:0] != PROTO_UDP)
				return ST_NOT_UDP;
			if (n < udp_base() + UDP_HDR_LEN)
				return ST_TRUNC;
			return ST_OK;
		end
		if (hdr_etype == ETH_IPV6) begin
			if (n < LEN_V6_VER)
				return ST_TRUNC;
			if (hdr_vihl[7:4] != IP_VER6)
				return ST_BAD_VER;
			if (n < LEN_V6_UDP)
				return ST_TRUNC;
			return ST_OK;
		end
		return ST_BAD_ETYPE;
	endfunction

	task automatic capture_byte(input int unsigned p, input logic [7:0] b);
		int unsigned ub;
		int unsigned w;
		if (p < 6)
			hdr_dmac = {hdr_dmac[39:0], b};
		else if (p < 12)
			hdr_smac = {hdr_smac[39:0], b};
		else if (p < 14)
			hdr_etype = {hdr_etype[7:0], b};
		else begin
			if (p == 14)
				hdr_vihl = b;
			if (hdr_etype == ETH_IPV4) begin
				ub = udp_base();
				if (p == 20 || p == 21 || p == 23)
					hdr_fragp = {hdr_fragp[15:0], b};
				if (p >= 26 && p < 30)
					hdr_addr[1] = {hdr_addr[1][55:0], b};
				if (p >= 30 && p < 34)
					hdr_addr[3] = {hdr_addr[3][55:0], b};
				if (hdr_vihl[3:0] >= IHL_MIN && p >= ub && p < ub + 6)
					hdr_udp = {hdr_udp[39:0], b};
			end else if (hdr_etype == ETH_IPV6) begin
				if (p >= 22 && p < 54) begin
					w = ((p - 22) >> 3) & 3;
					hdr_addr[w] = {hdr_addr[w][55:0], b};
				end
				if (p >= 54 && p < 60)
					hdr_udp = {hdr_udp[39:0], b};
			end
		end
	endtask

	// one accepted byte; on the last byte the expected header result is queued
	task automatic absorb_byte(input logic [7:0] b, input logic l);
		hdr_result_t r;
		if (hdr_pos < MAX_BYTES) begin
			capture_byte(hdr_pos, b);
			hdr_pos++;
		end
		if (l) begin
			r = '0;
			r.st = classify_frame();
			if (r.st == ST_OK) begin
				r.v6 = (hdr_etype == ETH_IPV6);
				r.smac = hdr_smac;
				r.dmac = hdr_dmac;
				r.sah = hdr_addr[0];
				r.sal = hdr_addr[1];
				r.dah = hdr_addr[2];
				r.dal = hdr_addr[3];
				r.sp = hdr_udp[47:32];
				r.dp = hdr_udp[31:16];
				r.poff = 11'(udp_base() + UDP_HDR_LEN);
				r.plen = (hdr_udp[15:0] >= UDP_HDR_LEN) ? hdr_udp[15:0] - UDP_HDR_LEN : 16'd0;
				if (r.v6)
					clean_v6++;
				else
					clean_v4++;
			end else
				rejected++;
			pending_headers.push_back(r);
			hdr_pos = 0;
			hdr_etype = '0;
			hdr_dmac = '0;
			hdr_smac = '0;
			hdr_vihl = '0;
			hdr_fragp = '0;
			hdr_addr = '{default: '0};
			hdr_udp = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
		end
	endtask

	task automatic check_result();
		hdr_result_t want;
		if (pending_headers.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("result with nothing expected: status %0d", status);
			return;
		end
		want = pending_headers.pop_front();
		compare_field("status", want.st, status);
		compare_field("is_ipv6", want.v6, is_ipv6);
		compare_field("src_mac", want.smac, src_mac);
		compare_field("dst_mac", want.dmac, dst_mac);
		compare_field("src_addr_hi", want.sah, src_addr_hi);
		compare_field("src_addr_lo", want.sal, src_addr_lo);
		compare_field("dst_addr_hi", want.dah, dst_addr_hi);
		compare_field("dst_addr_lo", want.dal, dst_addr_lo);
		compare_field("src_port", want.sp, src_port);
		compare_field("dst_port", want.dp, dst_port);
		compare_field("payload_offset", want.poff, payload_offset);
		compare_field("udp_data_len", want.plen, udp_data_len);
		results_seen++;
	endtask

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			check_result();

	// called and returns at a falling edge; valid stays up for a following item
	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < sender_idle_pct) begin
			frame_valid <= 1'b0;
			@(negedge clk);
		end
		frame_valid <= 1'b1;
		frame_byte <= b;
		last <= l;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
		absorb_byte(b, l);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic hold_off();
		frame_valid <= 1'b0;
		while (pending_headers.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic make_frame(input logic [15:0] etype, input logic [3:0] ver,
			input logic [3:0] ihl, input logic [15:0] frag, input logic [7:0] proto,
			input logic [15:0] ulen, input int pay);
		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
		if (etype == ETH_IPV4) begin
			frame_buf.push_back({ver, ihl});
			repeat (5) frame_buf.push_back(8'($urandom));
			frame_buf.push_back(frag[15:8]);
			frame_buf.push_back(frag[7:0]);
			frame_buf.push_back(8'($urandom));
			frame_buf.push_back(proto);
			repeat (10) frame_buf.push_back(8'($urandom));
			if (ihl > IHL_MIN)
				repeat (4 * (int'(ihl) - int'(IHL_MIN))) frame_buf.push_back(8'($urandom));
		end else if (etype == ETH_IPV6) begin
			frame_buf.push_back({ver, 4'($urandom)});
			repeat (39) frame_buf.push_back(8'($urandom));
		end else
			repeat ($urandom_range(40)) frame_buf.push_back(8'($urandom));
		repeat (4) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(ulen[15:8]);
		frame_buf.push_back(ulen[7:0]);
		repeat (2) frame_buf.push_back(8'($urandom));
		repeat (pay) frame_buf.push_back(8'($urandom));
	endtask

	task automatic put16(input int at, input logic [15:0] v);
		frame_buf[at] = v[15:8];
		frame_buf[at + 1] = v[7:0];
	endtask

	// cut of zero sends the whole frame
	task automatic send_frame(input int cut);
		int n;
		int i;
		n = frame_buf.size();
		if (cut > 0 && cut < n)
			n = cut;
		for (i = 0; i < n; i++)
			send_byte(frame_buf[i], i == n - 1);
		frames_sent++;
	endtask

	task automatic test_short_frames();
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 0);
		send_frame(1);
		send_frame(13);
		send_frame(14);
		send_frame(21);
		send_frame(22);
		send_frame(23);
		send_frame(41);
		make_frame(ETH_IPV4, IP_VER6, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 0);
		send_frame(22);
		make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, 16'd20, 0);
		send_frame(14);
		send_frame(15);
		send_frame(61);
		make_frame(ETH_IPV6, IP_VER4, 4'h0, 16'h0, 8'h0, 16'd20, 0);
		send_frame(15);
	endtask

	task automatic test_ipv4_headers();
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd8, 0);
		put16(34, 16'h0000);
		put16(36, 16'hFFFF);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, 4'hF, FRAG_DF, PROTO_UDP, 16'hFFFF, 3);
		put16(74, 16'hFFFF);
		put16(76, 16'h0000);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, 4'h6, 16'h0, PROTO_UDP, 16'd0, 2);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd7, 0);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, 4'h4, 16'h0, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, 4'h0, 16'h0, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, 4'hF, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h2000, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0001, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'hFFFF, PROTO_UDP, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, FRAG_DF, 8'h06, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0, 8'h00, 16'd20, 4);
		send_frame(0);
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, 16'h0, 8'hFF, 16'd20, 4);
		send_frame(0);
	endtask

	task automatic test_ipv6_headers();
		make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, 16'd9, 1);
		send_frame(0);
		make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, 16'hFFFF, 0);
		put16(54, 16'hFFFF);
		put16(56, 16'h0000);
		send_frame(0);
		make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, 16'd0, 2);
		send_frame(0);
		make_frame(ETH_IPV6, 4'h0, 4'h0, 16'h0, 8'h0, 16'd20, 2);
		send_frame(0);
		make_frame(ETH_IPV6, 4'hF, 4'h0, 16'h0, 8'h0, 16'd20, 2);
		send_frame(0);
	endtask

	task automatic test_other_ethertypes();
		make_frame(16'h0000, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 2);
		send_frame(0);
		make_frame(16'hFFFF, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 2);
		send_frame(0);
		make_frame(16'h86DC, IP_VER6, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 2);
		send_frame(0);
		make_frame(16'h0801, IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, 16'd20, 2);
		send_frame(0);
	endtask

	task automatic test_oversize_frame();
		make_frame(ETH_IPV4, IP_VER4, IHL_MIN, FRAG_DF, PROTO_UDP, 16'd2108, MAX_BYTES + 60);
		send_frame(0);
		hold_off();
	endtask

	// mostly well-formed frames with random content, the rest broken or noise
	task automatic make_random_frame(output int cut);
		int r;
		logic [15:0] ulen;
		int pay;
		r = $urandom_range(99);
		ulen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
		pay = $urandom_range(12);
		cut = 0;
		if (r < 45)
			make_frame(ETH_IPV4, IP_VER4,
				($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : IHL_MIN,
				$urandom_range(1) ? FRAG_DF : 16'h0, PROTO_UDP, ulen, pay);
		else if (r < 70)
			make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, ulen, pay);
		else if (r < 80) begin
			if ($urandom_range(1))
				make_frame(ETH_IPV4, IP_VER4, 4'($urandom_range(15, 5)), 16'h0, PROTO_UDP,
					ulen, pay);
			else
				make_frame(ETH_IPV6, IP_VER6, 4'h0, 16'h0, 8'h0, ulen, pay);
			cut = $urandom_range(frame_buf.size(), 1);
		end else if (r < 88)
			make_frame(ETH_IPV4, $urandom_range(1) ? 4'($urandom) : IP_VER4, 4'($urandom),
				$urandom_range(1) ? 16'($urandom) : FRAG_DF,
				$urandom_range(1) ? 8'($urandom) : PROTO_UDP, ulen, pay);
		else if (r < 93)
			make_frame(ETH_IPV6, 4'($urandom), 4'h0, 16'h0, 8'h0, ulen, pay);
		else if (r < 97)
			make_frame(16'($urandom), IP_VER4, IHL_MIN, 16'h0, PROTO_UDP, ulen, pay);
		else begin
			frame_buf.delete();
			repeat ($urandom_range(40, 1)) frame_buf.push_back(8'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		int idle [4] = '{0, 68, 0, 9};
		int stall [4] = '{0, 0, 68, 9};
		int ph;
		int b0;
		int f0;
		int cut;
		for (ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle[ph];
			recv_stall_pct = stall[ph];
			b0 = bytes_sent;
			f0 = frames_sent;
			while (bytes_sent - b0 < PHASE_BYTES || frames_sent - f0 < PHASE_FRAMES) begin
				make_random_frame(cut);
				send_frame(cut);
			end
			hold_off();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_short_frames();
		test_ipv4_headers();
		test_ipv6_headers();
		test_other_ethertypes();
		test_oversize_frame();
		test_random_traffic();
		recv_stall_pct = 0;
		frame_valid <= 1'b0;
		while (pending_headers.size() != 0 && drain_cycles < 2000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_headers.size() != 0) begin
			$display("%0d expected results never arrived", pending_headers.size());
			mismatches += pending_headers.size();
		end
		$display("sent %0d bytes in %0d frames, including truncated, oversize and noise frames",
			bytes_sent, frames_sent);
		$display("checked %0d results: %0d clean IPv4, %0d clean IPv6, %0d rejected",
			results_seen, clean_v4, clean_v6, rejected);
		if (mismatches == 0)
			$display("** udp_ip_frame_parser_top: PASSED **");
		else
			$display("** udp_ip_frame_parser_top: FAILED **");
		$finish;
	end

endmodule
